// ===== hdl/pwpt_pkg.sv =====
// Shared constants, codes and types of the pairing window controller.
package pwpt_pkg;

    localparam int MAX_PEERS  = 8;
    localparam int PEER_BITS  = 64;
    localparam int LABEL_BITS = 64;

    localparam int TIME_BITS = 48;
    localparam int LEN_BITS  = 32;
    localparam int CODE_BITS = 8;
    localparam int CFG_BITS  = 32;
    localparam int CFG_IDX_BITS = 2;

    // A count runs from 0 to MAX_PEERS; an address from 0 to MAX_PEERS - 1.
    localparam int CNT_W  = $clog2(MAX_PEERS + 1);
    localparam int ADDR_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CODE_LOWEST   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CODE_HIGHEST  = 2'd2;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_CODE    = 2'd1,
        OP_TICK    = 2'd2,
        OP_UNPAIR  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_PAIRED    = 3'd1,
        ACT_REJECTED  = 3'd2,
        ACT_BLINK     = 3'd3,
        ACT_UNPAIRED  = 3'd4,
        ACT_NOT_FOUND = 3'd5
    } action_t;

    // Write and count controls from the sequencer to the peer table.
    typedef struct packed {
        logic                  peer_en;
        logic                  label_en;
        logic [ADDR_W-1:0]     addr;
        logic [PEER_BITS-1:0]  peer;
        logic [LABEL_BITS-1:0] label;
        logic                  inc;
        logic                  dec;
    } tbl_wr_t;

endpackage

// ===== hdl/pairing_window_with_peer_table_core.sv =====
// Top level of the pairing window controller: sequencer, window state and result register.
//
// The block keeps a table of up to eight paired peers and one pairing window. Each input
// transfer carries an opcode (pair request, code confirmation, time tick, unpair) and
// produces exactly one result transfer with the action, the blink code and the number of
// paired peers after the step. One item occupies the block until its result is written: the
// sequencer walks the table one entry per cycle through a single shared comparator to find
// the peer, and an unpair then moves the later entries down one per cycle through the same
// table port. in_stall stays high from the accepted transfer until the result has been
// written into the output register, which may still be waiting on out_stall while the next
// item is accepted. Configuration writes take effect at once and are expected only while
// the block is idle. The table comes up empty after reset with no clearing pass.
module pairing_window_with_peer_table_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [pwpt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [pwpt_pkg::CFG_BITS-1:0]    cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       opcode,
    input  logic [63:0]                      peer_token,
    input  logic [63:0]                      label_token,
    input  logic [47:0]                      now_ms,
    input  logic [7:0]                       pair_code,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       action,
    output logic [7:0]                       blink_code,
    output logic [3:0]                       peer_count
);
    import pwpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;

    // Latched input item.
    opcode_t               op_reg, op_next;
    logic [PEER_BITS-1:0]  peer_reg, peer_next;
    logic [LABEL_BITS-1:0] label_reg, label_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [CODE_BITS-1:0]  code_reg, code_next;

    // Search position and result.
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  found_reg, found_next;

    // Pairing window.
    logic                  win_open_reg, win_open_next;
    logic [TIME_BITS-1:0]  deadline_reg, deadline_next;
    logic [PEER_BITS-1:0]  pend_peer_reg, pend_peer_next;
    logic [LABEL_BITS-1:0] pend_label_reg, pend_label_next;
    logic [CODE_BITS-1:0]  pend_code_reg, pend_code_next;

    // Configuration registers.
    logic [LEN_BITS-1:0]   win_len_reg, win_len_next;
    logic [CODE_BITS-1:0]  code_lo_reg, code_lo_next;
    logic [CODE_BITS-1:0]  code_hi_reg, code_hi_next;

    // Result waiting for the output register, and the output register itself.
    action_t               res_act_reg, res_act_next;
    logic [CODE_BITS-1:0]  res_blink_reg, res_blink_next;
    logic                  out_valid_reg, out_valid_next;
    action_t               out_act_reg, out_act_next;
    logic [CODE_BITS-1:0]  out_blink_reg, out_blink_next;
    logic [3:0]            out_count_reg, out_count_next;

    tbl_wr_t               tbl_wr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [PEER_BITS-1:0]  rd_peer;
    logic [LABEL_BITS-1:0] rd_label;
    logic [CNT_W-1:0]      count;

    logic [TIME_BITS:0]    deadline_sum;
    logic [TIME_BITS-1:0]  new_deadline;
    logic                  expired;
    logic                  table_full;
    logic [CNT_W-1:0]      idx_plus;
    logic [PEER_BITS-1:0]  add_peer;
    logic [LABEL_BITS-1:0] add_label;
    logic [CODE_BITS-1:0]  clamped_code;

    pwpt_table u_table
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_addr  (rd_addr),
        .rd_peer  (rd_peer),
        .rd_label (rd_label),
        .count    (count)
    );

    // The deadline saturates at the largest time value.
    assign deadline_sum = {1'b0, now_reg} + (TIME_BITS + 1)'(win_len_reg);
    assign new_deadline = deadline_sum[TIME_BITS] ? '1 : deadline_sum[TIME_BITS-1:0];
    assign expired      = now_reg >= deadline_reg;
    assign table_full   = count == CNT_W'(MAX_PEERS);
    assign idx_plus     = idx_reg + CNT_W'(1);

    // A confirmation adds the pending peer; a request adds the requesting peer.
    assign add_peer  = (op_reg == OP_CODE) ? pend_peer_reg : peer_reg;
    assign add_label = (op_reg == OP_CODE) ? pend_label_reg : label_reg;

    assign clamped_code = (code_reg < code_lo_reg || code_reg > code_hi_reg)
                          ? code_lo_reg : code_reg;

    assign in_stall   = state_reg != S_IDLE;
    assign out_valid  = out_valid_reg;
    assign action     = out_act_reg;
    assign blink_code = out_blink_reg;
    assign peer_count = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        peer_next       = peer_reg;
        label_next      = label_reg;
        now_next        = now_reg;
        code_next       = code_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        win_open_next   = win_open_reg;
        deadline_next   = deadline_reg;
        pend_peer_next  = pend_peer_reg;
        pend_label_next = pend_label_reg;
        pend_code_next  = pend_code_reg;
        win_len_next    = win_len_reg;
        code_lo_next    = code_lo_reg;
        code_hi_next    = code_hi_reg;
        res_act_next    = res_act_reg;
        res_blink_next  = res_blink_reg;
        out_valid_next  = out_valid_reg;
        out_act_next    = out_act_reg;
        out_blink_next  = out_blink_reg;
        out_count_next  = out_count_reg;

        tbl_wr.peer_en  = 1'b0;
        tbl_wr.label_en = 1'b0;
        tbl_wr.addr     = idx_reg[ADDR_W-1:0];
        tbl_wr.peer     = add_peer;
        tbl_wr.label    = add_label;
        tbl_wr.inc      = 1'b0;
        tbl_wr.dec      = 1'b0;
        rd_addr         = idx_reg[ADDR_W-1:0];

        if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH: win_len_next = cfg_data[LEN_BITS-1:0];
                REG_CODE_LOWEST:   code_lo_next = cfg_data[CODE_BITS-1:0];
                REG_CODE_HIGHEST:  code_hi_next = cfg_data[CODE_BITS-1:0];
                default:           ;
            endcase
        end

        // The output register empties when its transfer completes.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode_t'(opcode);
                    peer_next  = peer_token[PEER_BITS-1:0];
                    label_next = label_token[LABEL_BITS-1:0];
                    now_next   = now_ms;
                    code_next  = pair_code;
                    state_next = S_PRE;
                end
            end

            S_PRE:
            begin
                idx_next       = '0;
                found_next     = 1'b0;
                res_blink_next = '0;
                res_act_next   = ACT_NONE;
                state_next     = S_SCAN;
                case (op_reg)
                    OP_REQUEST:
                    begin
                        if (peer_reg == '0)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (win_open_reg && expired)
                        begin
                            // A stale window is dropped before the request is handled.
                            win_open_next   = 1'b0;
                            deadline_next   = '0;
                            pend_peer_next  = '0;
                            pend_label_next = '0;
                            pend_code_next  = '0;
                        end
                    end
                    OP_CODE:
                    begin
                        if (peer_reg == '0)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (!win_open_reg)
                        begin
                            res_act_next = ACT_REJECTED;
                            state_next   = S_FINISH;
                        end
                        else if (expired || pend_peer_reg != peer_reg
                                 || code_reg != pend_code_reg)
                        begin
                            win_open_next   = 1'b0;
                            deadline_next   = '0;
                            pend_peer_next  = '0;
                            pend_label_next = '0;
                            pend_code_next  = '0;
                            res_act_next    = ACT_REJECTED;
                            state_next      = S_FINISH;
                        end
                    end
                    OP_TICK:
                    begin
                        if (win_open_reg && expired)
                        begin
                            win_open_next   = 1'b0;
                            deadline_next   = '0;
                            pend_peer_next  = '0;
                            pend_label_next = '0;
                            pend_code_next  = '0;
                            res_act_next    = ACT_REJECTED;
                        end
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_SCAN;
                    end
                endcase
            end

            S_SCAN:
            begin
                // One entry per cycle through the shared comparator; idx stops on a match.
                if (idx_reg == count)
                begin
                    state_next = S_DECIDE;
                end
                else if (rd_peer == peer_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = idx_plus;
                end
            end

            S_DECIDE:
            begin
                state_next = S_FINISH;
                case (op_reg)
                    OP_REQUEST, OP_CODE:
                    begin
                        if (found_reg)
                        begin
                            // Known peer: refresh the label when one is given.
                            tbl_wr.label_en = add_label != '0;
                            win_open_next   = 1'b0;
                            deadline_next   = '0;
                            pend_peer_next  = '0;
                            pend_label_next = '0;
                            pend_code_next  = '0;
                            res_act_next    = ACT_PAIRED;
                        end
                        else if ((op_reg == OP_CODE || count == '0) && !table_full)
                        begin
                            // Add at the end; a missing label becomes the peer token.
                            tbl_wr.addr     = count[ADDR_W-1:0];
                            tbl_wr.peer_en  = 1'b1;
                            tbl_wr.label_en = 1'b1;
                            tbl_wr.label    = (add_label != '0) ? add_label
                                              : LABEL_BITS'(add_peer);
                            tbl_wr.inc      = 1'b1;
                            win_open_next   = 1'b0;
                            deadline_next   = '0;
                            pend_peer_next  = '0;
                            pend_label_next = '0;
                            pend_code_next  = '0;
                            res_act_next    = ACT_PAIRED;
                        end
                        else if (table_full)
                        begin
                            if (op_reg == OP_CODE)
                            begin
                                win_open_next   = 1'b0;
                                deadline_next   = '0;
                                pend_peer_next  = '0;
                                pend_label_next = '0;
                                pend_code_next  = '0;
                            end
                            res_act_next = ACT_REJECTED;
                        end
                        else if (win_open_reg && pend_peer_reg == peer_reg)
                        begin
                            // Repeated request from the pending peer extends the window.
                            deadline_next  = new_deadline;
                            res_blink_next = pend_code_reg;
                            res_act_next   = ACT_BLINK;
                        end
                        else
                        begin
                            win_open_next   = 1'b1;
                            pend_peer_next  = peer_reg;
                            pend_label_next = label_reg;
                            pend_code_next  = clamped_code;
                            deadline_next   = new_deadline;
                            res_blink_next  = clamped_code;
                            res_act_next    = ACT_BLINK;
                        end
                    end
                    OP_UNPAIR:
                    begin
                        if (found_reg)
                        begin
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            res_act_next = ACT_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_act_next = ACT_NONE;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // Move the next entry down into the current place, one per cycle.
                if (idx_plus < count)
                begin
                    rd_addr         = idx_plus[ADDR_W-1:0];
                    tbl_wr.peer_en  = 1'b1;
                    tbl_wr.label_en = 1'b1;
                    tbl_wr.peer     = rd_peer;
                    tbl_wr.label    = rd_label;
                    idx_next        = idx_plus;
                end
                else
                begin
                    tbl_wr.dec   = 1'b1;
                    res_act_next = ACT_UNPAIRED;
                    state_next   = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = res_act_reg;
                    out_blink_next = (res_act_reg == ACT_BLINK) ? res_blink_reg : '0;
                    out_count_next = 4'(count);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            win_open_reg   <= 1'b0;
            deadline_reg   <= '0;
            pend_peer_reg  <= '0;
            pend_label_reg <= '0;
            pend_code_reg  <= '0;
            win_len_reg    <= LEN_BITS'(60000);
            code_lo_reg    <= CODE_BITS'(1);
            code_hi_reg    <= CODE_BITS'(9);
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            win_open_reg   <= win_open_next;
            deadline_reg   <= deadline_next;
            pend_peer_reg  <= pend_peer_next;
            pend_label_reg <= pend_label_next;
            pend_code_reg  <= pend_code_next;
            win_len_reg    <= win_len_next;
            code_lo_reg    <= code_lo_next;
            code_hi_reg    <= code_hi_next;
            out_valid_reg  <= out_valid_next;
            found_reg      <= found_next;
            idx_reg        <= idx_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        peer_reg      <= peer_next;
        label_reg     <= label_next;
        now_reg       <= now_next;
        code_reg      <= code_next;
        res_act_reg   <= res_act_next;
        res_blink_reg <= res_blink_next;
        out_act_reg   <= out_act_next;
        out_blink_reg <= out_blink_next;
        out_count_reg <= out_count_next;
    end

endmodule

// ===== hdl/pwpt_table.sv =====
// Peer table storage: peer and label entries, one read and one write port, and the fill count.
module pwpt_table
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  pwpt_pkg::tbl_wr_t               wr,
    input  logic [pwpt_pkg::ADDR_W-1:0]     rd_addr,
    output logic [pwpt_pkg::PEER_BITS-1:0]  rd_peer,
    output logic [pwpt_pkg::LABEL_BITS-1:0] rd_label,
    output logic [pwpt_pkg::CNT_W-1:0]      count
);
    import pwpt_pkg::*;

    logic [PEER_BITS-1:0]  peers_reg  [MAX_PEERS];
    logic [LABEL_BITS-1:0] labels_reg [MAX_PEERS];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // Entries at or above the count are never read, so the arrays need no reset.
    always_ff @(posedge clk)
    begin
        if (wr.peer_en)
        begin
            peers_reg[wr.addr] <= wr.peer;
        end
        if (wr.label_en)
        begin
            labels_reg[wr.addr] <= wr.label;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (wr.inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (wr.dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rd_peer  = peers_reg[rd_addr];
    assign rd_label = labels_reg[rd_addr];
    assign count    = count_reg;

endmodule

// ===== tb/pairing_checker.sv =====
// Checker that predicts and compares the results of the pairing window controller.
`timescale 1ns / 100ps

module pairing_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pwpt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [pwpt_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic [63:0]                       peer_token,
    input  logic [63:0]                       label_token,
    input  logic [47:0]                       now_ms,
    input  logic [7:0]                        pair_code,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [2:0]                        action,
    input  logic [7:0]                        blink_code,
    input  logic [3:0]                        peer_count,
    output int                                mismatches,
    output int                                awaiting
);

    import pwpt_pkg::*;

    typedef struct packed {
        action_t    act;
        logic [7:0] blink;
        logic [3:0] count;
    } outcome_t;

    // Configuration as last written.
    logic [31:0] win_len;
    logic [7:0]  code_lo;
    logic [7:0]  code_hi;

    // Window and table state.
    logic        win_open;
    logic [47:0] win_deadline;
    logic [63:0] pend_peer;
    logic [63:0] pend_label;
    logic [7:0]  pend_code;
    logic [63:0] peer_tab [MAX_PEERS];
    logic [63:0] label_tab [MAX_PEERS];
    int          peer_total;

    outcome_t awaited_outcomes [$];
    outcome_t want;

    function automatic void close_window();
        win_open     = 1'b0;
        win_deadline = '0;
        pend_peer    = '0;
        pend_label   = '0;
        pend_code    = '0;
    endfunction

    // The deadline saturates at the largest time rather than wrapping.
    function automatic logic [47:0] deadline_at(logic [47:0] t);
        logic [48:0] sum;
        sum = {1'b0, t} + {17'd0, win_len};
        return sum[48] ? {48{1'b1}} : sum[47:0];
    endfunction

    function automatic int peer_slot(logic [63:0] p);
        for (int i = 0; i < peer_total; i++)
            if (peer_tab[i] == p)
                return i;
        return -1;
    endfunction

    // Refreshes a known peer or appends a new one; zero when the table is full.
    function automatic bit store_peer(logic [63:0] p, logic [63:0] lbl);
        int at;
        at = peer_slot(p);
        if (at >= 0)
        begin
            if (lbl != '0)
                label_tab[at] = lbl;
            return 1'b1;
        end
        if (peer_total >= MAX_PEERS)
            return 1'b0;
        peer_tab[peer_total]  = p;
        label_tab[peer_total] = (lbl != '0) ? lbl : p;
        peer_total++;
        return 1'b1;
    endfunction

    function automatic action_t take_request(logic [63:0] p, logic [63:0] lbl,
                                             logic [47:0] t, logic [7:0] c,
                                             output logic [7:0] blink);
        blink = '0;
        if (win_open && t >= win_deadline)
            close_window();
        if (peer_slot(p) >= 0)
        begin
            void'(store_peer(p, lbl));
            close_window();
            return ACT_PAIRED;
        end
        if (peer_total == 0)
        begin
            if (!store_peer(p, lbl))
                return ACT_REJECTED;
            close_window();
            return ACT_PAIRED;
        end
        if (peer_total >= MAX_PEERS)
            return ACT_REJECTED;
        if (win_open && pend_peer == p)
        begin
            win_deadline = deadline_at(t);
            blink = pend_code;
            return ACT_BLINK;
        end
        if (c < code_lo || c > code_hi)
            c = code_lo;
        close_window();
        win_open     = 1'b1;
        pend_peer    = p;
        pend_label   = lbl;
        pend_code    = c;
        win_deadline = deadline_at(t);
        blink = c;
        return ACT_BLINK;
    endfunction

    function automatic action_t take_code(logic [63:0] p, logic [7:0] c, logic [47:0] t);
        bit added;
        if (!win_open)
            return ACT_REJECTED;
        if (t >= win_deadline || pend_peer != p || c != pend_code)
        begin
            close_window();
            return ACT_REJECTED;
        end
        added = store_peer(pend_peer, pend_label);
        close_window();
        return added ? ACT_PAIRED : ACT_REJECTED;
    endfunction

    function automatic action_t take_unpair(logic [63:0] p);
        int at;
        at = peer_slot(p);
        if (at < 0)
            return ACT_NOT_FOUND;
        for (int i = at; i + 1 < peer_total; i++)
        begin
            peer_tab[i]  = peer_tab[i + 1];
            label_tab[i] = label_tab[i + 1];
        end
        peer_total--;
        peer_tab[peer_total]  = '0;
        label_tab[peer_total] = '0;
        return ACT_UNPAIRED;
    endfunction

    function automatic outcome_t pairing_step(logic [1:0] op, logic [63:0] p,
                                              logic [63:0] lbl, logic [47:0] t,
                                              logic [7:0] c);
        outcome_t   r;
        logic [7:0] blink;
        r.act   = ACT_NONE;
        r.blink = '0;
        blink   = '0;
        case (op)
            OP_REQUEST:
                if (p != '0)
                    r.act = take_request(p, lbl, t, c, blink);
            OP_CODE:
                if (p != '0)
                    r.act = take_code(p, c, t);
            OP_TICK:
                if (win_open && t >= win_deadline)
                begin
                    close_window();
                    r.act = ACT_REJECTED;
                end
            default:
                r.act = take_unpair(p);
        endcase
        if (r.act == ACT_BLINK)
            r.blink = blink;
        r.count = peer_total[3:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len  = 32'd60000;
            code_lo  = 8'd1;
            code_hi  = 8'd9;
            close_window();
            for (int i = 0; i < MAX_PEERS; i++)
            begin
                peer_tab[i]  = '0;
                label_tab[i] = '0;
            end
            peer_total = 0;
            awaited_outcomes.delete();
            mismatches <= 0;
            awaiting   <= 0;
        end
        else
        begin
            // A result leaving now always belongs to an earlier transfer, so compare first.
            if (out_valid && !out_stall)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $error("result with nothing awaited: action %0d, blink_code %0d, "
                           , action, blink_code, "peer_count %0d", peer_count);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (action !== want.act || blink_code !== want.blink
                        || peer_count !== want.count)
                        mismatches <= mismatches + 1;
                    if (action !== want.act)
                        $error("action: expected %0d, got %0d", want.act, action);
                    if (blink_code !== want.blink)
                        $error("blink_code: expected %0d, got %0d", want.blink, blink_code);
                    if (peer_count !== want.count)
                        $error("peer_count: expected %0d, got %0d", want.count, peer_count);
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_WINDOW_LENGTH)
                    win_len = cfg_data[31:0];
                else if (cfg_index == REG_CODE_LOWEST)
                    code_lo = cfg_data[7:0];
                else if (cfg_index == REG_CODE_HIGHEST)
                    code_hi = cfg_data[7:0];
            end
            if (in_valid && !in_stall)
                awaited_outcomes.push_back(pairing_step(opcode, peer_token, label_token,
                                                        now_ms, pair_code));
            awaiting <= awaited_outcomes.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the pairing window controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

    import pwpt_pkg::*;

    // The slowest correct run is near 1750 items; the limit allows far more.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 243;
    localparam int POOL_SIZE   = 12;
    localparam logic [47:0] TIME_TOP = {48{1'b1}};

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data  = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic [1:0]              opcode      = '0;
    logic [63:0]             peer_token  = '0;
    logic [63:0]             label_token = '0;
    logic [47:0]             now_ms      = '0;
    logic [7:0]              pair_code   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [2:0]              action;
    logic [7:0]              blink_code;
    logic [3:0]              peer_count;

    int mismatches;
    int awaiting;
    int cycle_count = 0;
    int sent = 0;

    // When set, neither side inserts any idle cycles.
    bit quiet = 1'b0;

    // The stimulus keeps its own copy of the settings it wrote, only to aim codes and times.
    logic [31:0] win_len_set = 32'd60000;
    logic [7:0]  lo_set      = 8'd1;
    logic [7:0]  hi_set      = 8'd9;
    logic [47:0] clock_ms    = '0;
    logic [63:0] pool [POOL_SIZE];

    pairing_window_with_peer_table_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .peer_token  (peer_token),
        .label_token (label_token),
        .now_ms      (now_ms),
        .pair_code   (pair_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .action      (action),
        .blink_code  (blink_code),
        .peer_count  (peer_count)
    );

    pairing_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .peer_token  (peer_token),
        .label_token (label_token),
        .now_ms      (now_ms),
        .pair_code   (pair_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .action      (action),
        .blink_code  (blink_code),
        .peer_count  (peer_count),
        .mismatches  (mismatches),
        .awaiting    (awaiting)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The run is cut off if it ever hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL pairing_window_with_peer_table_core");
            $finish;
        end
    end

    // Idle length for one transfer. Short gaps are favored so that every stage of the
    // search and shift sequence sees some of them.
    function automatic int gap_draw();
        if (quiet)
            return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(1, 3);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Labels are often left out so that the token falls back as its own label.
    function automatic logic [63:0] pick_label();
        return ($urandom_range(0, 3) == 0) ? 64'd0 : rand64();
    endfunction

    // Proposed codes mostly land inside the configured range.
    function automatic logic [7:0] pick_code();
        if (lo_set <= hi_set && $urandom_range(0, 3) != 0)
            return 8'($urandom_range(lo_set, hi_set));
        return 8'($urandom_range(0, 255));
    endfunction

    // The code the block will blink for a fresh window.
    function automatic logic [7:0] fit_code(logic [7:0] c);
        return (c < lo_set || c > hi_set) ? lo_set : c;
    endfunction

    // A time advance that stays inside an open window.
    function automatic logic [47:0] inside_window();
        if (win_len_set == 0)
            return '0;
        return {16'd0, 32'($urandom_range(0, win_len_set - 1))};
    endfunction

    // A general time advance: often none, often a fraction of the window, sometimes
    // at or just past its end.
    function automatic logic [47:0] ms_step();
        case ($urandom_range(0, 9))
            0, 1, 2:    return '0;
            3, 4, 5, 6: return {16'd0, 32'($urandom_range(0, win_len_set / 8))};
            7, 8:       return {16'd0, win_len_set} + 48'($urandom_range(0, 2));
            default:    return {16'd0, 32'($urandom_range(0, win_len_set))};
        endcase
    endfunction

    // The sender holds valid high between back-to-back items and lowers it only for a gap,
    // so valid is never dropped and raised in one step.
    task automatic send_op(opcode_t op, logic [63:0] p, logic [63:0] lbl, logic [47:0] t,
                           logic [7:0] c);
        int gap;
        gap = gap_draw();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        peer_token  <= p;
        label_token <= lbl;
        now_ms      <= t;
        pair_code   <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // Drops valid and waits until every awaited result has come out and the block rests.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    // Writes all three registers on consecutive cycles; only called while the block rests.
    task automatic set_window(logic [31:0] wl, logic [7:0] lo, logic [7:0] hi);
        cfg_write <= 1'b1;
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_data  <= wl;
        @(posedge clk);
        cfg_index <= REG_CODE_LOWEST;
        cfg_data  <= {24'd0, lo};
        @(posedge clk);
        cfg_index <= REG_CODE_HIGHEST;
        cfg_data  <= {24'd0, hi};
        @(posedge clk);
        cfg_write <= 1'b0;
        win_len_set = wl;
        lo_set      = lo;
        hi_set      = hi;
    endtask

    // Well-formed pairing: a request from a pool peer, sometimes repeated, followed mostly
    // by the matching confirmation, otherwise by a wrong code, a wrong peer or an expiry.
    task automatic pairing_attempt();
        logic [63:0] p;
        logic [7:0]  c;
        p = pool[$urandom_range(0, POOL_SIZE - 1)];
        c = pick_code();
        clock_ms += ms_step();
        send_op(OP_REQUEST, p, pick_label(), clock_ms, c);
        c = fit_code(c);
        if ($urandom_range(0, 4) == 0)
        begin
            clock_ms += inside_window();
            send_op(OP_REQUEST, p, pick_label(), clock_ms, pick_code());
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                clock_ms += inside_window();
                send_op(OP_CODE, p, rand64(), clock_ms, c);
            end
            6:
            begin
                send_op(OP_CODE, p, rand64(), clock_ms, c + 8'd1);
            end
            7:
            begin
                send_op(OP_CODE, pool[$urandom_range(0, POOL_SIZE - 1)], rand64(),
                        clock_ms, c);
            end
            8:
            begin
                clock_ms += {16'd0, win_len_set};
                send_op(OP_TICK, rand64(), rand64(), clock_ms, pick_code());
            end
            default:
            begin
                clock_ms += {16'd0, win_len_set};
                send_op(OP_CODE, p, rand64(), clock_ms, c);
            end
        endcase
    endtask

    // One random phase under the current settings.
    task automatic random_items(int count);
        int start;
        int pick;
        start = sent;
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = rand64();
        pool[0] = {64{1'b1}};
        clock_ms = {8'($urandom_range(0, 255)), 40'd0} | {16'd0, $urandom};
        while (sent - start < count)
        begin
            // Stretches without any idling on either side alternate with idling ones.
            if ((sent % 60) == 0)
                quiet = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                pairing_attempt();
            else if (pick < 52)
            begin
                clock_ms += ms_step();
                send_op(OP_REQUEST, pool[$urandom_range(0, POOL_SIZE - 1)], pick_label(),
                        clock_ms, pick_code());
            end
            else if (pick < 66)
                send_op(OP_UNPAIR, pool[$urandom_range(0, POOL_SIZE - 1)], rand64(),
                        clock_ms, 8'($urandom_range(0, 255)));
            else if (pick < 80)
            begin
                clock_ms += ms_step();
                send_op(OP_TICK, rand64(), rand64(), clock_ms, 8'($urandom_range(0, 255)));
            end
            else if (pick < 88)
                send_op(OP_CODE, pool[$urandom_range(0, POOL_SIZE - 1)], rand64(),
                        clock_ms, pick_code());
            else
                // Noise: any opcode, any token including the empty one, any time.
                send_op(opcode_t'($urandom_range(0, 3)),
                        ($urandom_range(0, 7) == 0) ? 64'd0 : rand64(), pick_label(),
                        ($urandom_range(0, 9) == 0) ? 48'(rand64())
                                                    : {16'd0, clock_ms[31:0]},
                        8'($urandom_range(0, 255)));
        end
        drain();
    endtask

    // The receiver stalls for a freshly drawn number of cycles after each result transfer.
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                hold = gap_draw();
                if (hold > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        logic [63:0] pa;
        logic [63:0] pb;
        logic [63:0] pc;
        logic [63:0] pd;
        logic [63:0] pe;
        logic [47:0] t;
        pa = 64'd1;
        pb = {64{1'b1}};
        pc = 64'h8000_0000_0000_0000;
        pd = 64'h0123_4567_89AB_CDEF;
        pe = 64'hFEDC_BA98_7654_3210;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed part under the reset settings: window 60000 ms, codes 1 to 9.
        t = 48'd1000;
        // Missing peers and empty-table cases.
        send_op(OP_TICK, '0, '0, t, 8'd0);
        send_op(OP_REQUEST, '0, {64{1'b1}}, t, 8'd5);
        send_op(OP_CODE, '0, '0, t, 8'd1);
        send_op(OP_UNPAIR, '0, '0, t, 8'd0);
        send_op(OP_UNPAIR, pa, '0, t, 8'd0);
        // First peer goes straight into the empty table, then label refreshes.
        send_op(OP_REQUEST, pa, '0, t, 8'd0);
        send_op(OP_REQUEST, pa, {64{1'b1}}, t, 8'd255);
        send_op(OP_REQUEST, pa, '0, t, 8'd3);
        // Confirmation with no window open.
        send_op(OP_CODE, pa, '0, t, 8'd1);
        // Code above the range falls back to the lowest; a repeat keeps it.
        send_op(OP_REQUEST, pb, pc, t, 8'd200);
        send_op(OP_REQUEST, pb, '0, t + 48'd10, 8'd5);
        send_op(OP_CODE, pb, '0, t + 48'd11, 8'd2);
        send_op(OP_REQUEST, pb, '0, t + 48'd20, 8'd9);
        send_op(OP_CODE, pc, '0, t + 48'd21, 8'd9);
        // Code below the range, then tick just before and exactly at the deadline.
        t = 48'd500000;
        send_op(OP_REQUEST, pb, '0, t, 8'd0);
        send_op(OP_TICK, '0, '0, t + 48'd59999, 8'd0);
        send_op(OP_TICK, '0, '0, t + 48'd60000, 8'd0);
        // A stale window is replaced by the new request, which then pairs.
        t = 48'd900000;
        send_op(OP_REQUEST, pb, '0, t, 8'd5);
        send_op(OP_REQUEST, pb, '0, t + 48'd60000, 8'd7);
        send_op(OP_CODE, pb, '0, t + 48'd60001, 8'd7);
        // Confirmation that arrives at the deadline.
        t = 48'd2000000;
        send_op(OP_REQUEST, pc, '0, t, 8'd3);
        send_op(OP_CODE, pc, '0, t + 48'd60000, 8'd3);
        // Removing the first entry shifts the other one down.
        send_op(OP_UNPAIR, pa, '0, t, 8'd0);
        // The deadline saturates at the top of the time range.
        send_op(OP_REQUEST, pd, '0, TIME_TOP - 48'd5, 8'd4);
        send_op(OP_TICK, '0, '0, TIME_TOP - 48'd1, 8'd0);
        send_op(OP_TICK, '0, '0, TIME_TOP, 8'd0);
        // Time running backwards is taken as given.
        send_op(OP_REQUEST, pe, '0, 48'd100, 8'd255);
        send_op(OP_CODE, pe, '0, 48'd50, 8'd1);

        random_items(PHASE_ITEMS);

        // Settings at the extremes: a 1 ms window with the widest code range, the longest
        // window with a single code, a zero window with an inverted range, and so on.
        set_window(32'd1, 8'd0, 8'd255);
        random_items(PHASE_ITEMS);
        set_window(32'hFFFF_FFFF, 8'd255, 8'd255);
        random_items(PHASE_ITEMS);
        set_window(32'd0, 8'd7, 8'd3);
        random_items(PHASE_ITEMS);
        set_window(32'($urandom_range(2, 100000)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        random_items(PHASE_ITEMS);
        set_window(32'd5000, 8'd0, 8'd0);
        random_items(PHASE_ITEMS);
        set_window(32'd60000, 8'd1, 8'd9);
        random_items(PHASE_ITEMS);

        if (mismatches == 0)
            $display("PASS pairing_window_with_peer_table_core");
        else
            $display("FAIL pairing_window_with_peer_table_core");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pwpt_pkg.sv
hdl/pwpt_table.sv
hdl/pairing_window_with_peer_table_core.sv
tb/pairing_checker.sv
tb/testbench.sv
